// ----- hw/rtl/eit_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eit_pkg: shared types and constants of the event interval tracker
// Widths, limits, register indexes, operation codes and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package eit_pkg;

    // log geometry
    localparam int LOG_DEPTH = 16;
    localparam int IDX_W     = $clog2(LOG_DEPTH);
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

    // field widths
    localparam int TIME_W     = 32;
    localparam int WIN_W      = 17;
    localparam int MINP_W     = 12;
    localparam int THR_W      = 12;
    localparam int SHOW_W     = 12;
    localparam int OUT_CNT_W  = 5;
    localparam int SOUND_W    = 2;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_FLD_W  = 1 + SHOW_W + OUT_CNT_W + SOUND_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;
    localparam int DIV_CNT_W  = $clog2(TIME_W + 1);

    // time constants
    localparam int MINUTE_SECS   = 60;
    localparam int HOUR_MINUTES  = 60;
    localparam int SECS_PER_HOUR = HOUR_MINUTES * MINUTE_SECS;

    localparam logic [SHOW_W-1:0]    SHOW_CAP  = SHOW_W'(SECS_PER_HOUR - 1);
    localparam logic [OUT_CNT_W-1:0] COUNT_CAP = '1;

    // register reset values
    localparam logic [WIN_W-1:0]  WINDOW_RST    = WIN_W'(SECS_PER_HOUR);
    localparam logic [MINP_W-1:0] MIN_PHASE_RST = MINP_W'(20);
    localparam logic [THR_W-1:0]  GAP_THR_RST   = THR_W'(300);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PHASE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_THR   = CFG_IDX_W'(2);

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_PRESS = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [SOUND_W-1:0] {
        SND_NONE  = 2'd0,
        SND_START = 2'd1,
        SND_REST  = 2'd2,
        SND_CHIME = 2'd3
    } t_sound;

    // controller to datapath
    typedef struct packed {
        logic latch;        // capture the input transfer
        logic tick_upd;     // advance elapsed counter
        logic start_phase;  // rest -> contracting
        logic end_phase;    // contracting -> rest, log if long enough
        logic clear_log;    // reset-log operation
        logic expire_step;  // drop oldest entry
        logic rd_last;      // read address = newest entry
        logic cap_last;     // capture newest timestamp
        logic div_start;    // launch span / (count-1)
        logic cap_gap;      // capture quotient
        logic gap_zero;     // average gap is zero
        logic decide;       // pick rest beep or chime
        logic load_out;     // load output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic phase;
        logic log_empty;
        logic few;          // fewer than two entries
        logic expire_old;   // entry read is older than window start
        logic div_done;
    } t_dp_status;

endpackage

// ----- hw/rtl/eit_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eit_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module eit_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/eit_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eit_div: serial restoring divider
// One quotient bit per cycle; done pulses for a single cycle once the last bit is in the quotient register.
// ----------------------------------------------------------------------------
module eit_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [eit_pkg::TIME_W-1:0] i_dividend,
    input  logic [eit_pkg::CNT_W-1:0]  i_divisor,
    output logic [eit_pkg::TIME_W-1:0] o_quotient,
    output logic                       o_done
);

    import eit_pkg::*;

    logic [TIME_W-1:0]    r_quo, n_quo;
    logic [CNT_W-1:0]     r_rem, n_rem;
    logic [CNT_W-1:0]     r_dsr;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W:0]       shifted;
    logic                 fits;

    // one restoring step
    always_comb begin
        shifted = {r_rem, r_quo[TIME_W-1]};
        fits    = (shifted >= {1'b0, r_dsr});
        n_rem   = fits ? CNT_W'(shifted - {1'b0, r_dsr}) : shifted[CNT_W-1:0];
        n_quo   = {r_quo[TIME_W-2:0], fits};
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(TIME_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// ----- hw/rtl/eit_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eit_dp: datapath of the event interval tracker
// Configuration registers, phase and log state, timestamp RAM, divider and
// output payload register, all stepped by controller commands.
// ----------------------------------------------------------------------------
module eit_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  eit_pkg::t_dp_cmd               i_cmd,
    output eit_pkg::t_dp_status            o_stat,
    input  logic [eit_pkg::OP_W-1:0]       i_op,
    input  logic [eit_pkg::TIME_W-1:0]     i_now,
    input  logic                           i_cfg_valid,
    input  logic [eit_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [eit_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [eit_pkg::OUT_DATA_W-1:0] o_out_data
);

    import eit_pkg::*;

    // configuration
    logic [WIN_W-1:0]  r_window;
    logic [MINP_W-1:0] r_min_phase;
    logic [THR_W-1:0]  r_gap_thr;

    // tracker state
    logic              r_phase;
    logic [SHOW_W-1:0] r_elapsed;
    logic [IDX_W-1:0]  r_oldest;
    logic [IDX_W-1:0]  r_newest;
    logic              r_empty;
    logic              r_chime_done;
    logic [TIME_W-1:0] r_phase_start;
    logic              r_rest_pending;
    t_sound            r_sound;

    // per-item payload
    logic [OP_W-1:0]       r_op;
    logic [TIME_W-1:0]     r_now;
    logic [TIME_W-1:0]     r_win_start;
    logic [TIME_W-1:0]     r_last_time;
    logic [TIME_W-1:0]     r_gap;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [TIME_W-1:0]    win_start;
    logic                 long_phase;
    logic                 push;
    logic [IDX_W-1:0]     oldest_inc;
    logic [IDX_W-1:0]     newest_inc;
    logic [IDX_W-1:0]     last_idx;
    logic [IDX_W-1:0]     raddr;
    logic [TIME_W-1:0]    rdata;
    logic [CNT_W-1:0]     count;
    logic [CNT_W+OUT_CNT_W-1:0] count_ext;
    logic [OUT_CNT_W-1:0] count_out;
    logic [SHOW_W-1:0]    shown;
    logic [TIME_W-1:0]    quotient;
    logic                 div_done;
    logic                 chime_ok;

    // ring index arithmetic
    always_comb begin
        oldest_inc = (r_oldest == IDX_W'(LOG_DEPTH - 1)) ? '0 : r_oldest + IDX_W'(1);
        newest_inc = (r_newest == IDX_W'(LOG_DEPTH - 1)) ? '0 : r_newest + IDX_W'(1);
        last_idx   = (r_newest == '0) ? IDX_W'(LOG_DEPTH - 1) : r_newest - IDX_W'(1);
        raddr      = i_cmd.rd_last ? last_idx : r_oldest;
    end

    // entries held
    always_comb begin
        if (r_empty) begin
            count = '0;
        end else if (r_newest == r_oldest) begin
            count = CNT_W'(LOG_DEPTH);
        end else if (r_newest > r_oldest) begin
            count = CNT_W'(r_newest) - CNT_W'(r_oldest);
        end else begin
            count = CNT_W'(r_newest) + CNT_W'(LOG_DEPTH) - CNT_W'(r_oldest);
        end
        count_ext = (CNT_W + OUT_CNT_W)'(count);
        count_out = (count_ext > (CNT_W + OUT_CNT_W)'(COUNT_CAP)) ? COUNT_CAP
                                                                  : count_ext[OUT_CNT_W-1:0];
    end

    // window start saturates at zero
    assign win_start = (i_now > TIME_W'(r_window)) ? i_now - TIME_W'(r_window) : '0;

    assign long_phase = ((r_now - r_phase_start) > TIME_W'(r_min_phase));
    assign push       = i_cmd.end_phase && long_phase;

    assign chime_ok = (r_gap != '0) && (r_gap < TIME_W'(r_gap_thr)) && !r_chime_done;

    // displayed value
    always_comb begin
        if (r_phase) begin
            shown = r_elapsed;
        end else if (r_gap > TIME_W'(SHOW_CAP)) begin
            shown = SHOW_CAP;
        end else begin
            shown = r_gap[SHOW_W-1:0];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RST;
            r_min_phase <= MIN_PHASE_RST;
            r_gap_thr   <= GAP_THR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW:    r_window    <= i_cfg_data[WIN_W-1:0];
                CFG_MIN_PHASE: r_min_phase <= i_cfg_data[MINP_W-1:0];
                CFG_GAP_THR:   r_gap_thr   <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // tracker state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= 1'b0;
            r_elapsed      <= '0;
            r_oldest       <= '0;
            r_newest       <= '0;
            r_empty        <= 1'b1;
            r_chime_done   <= 1'b0;
            r_phase_start  <= '0;
            r_rest_pending <= 1'b0;
            r_sound        <= SND_NONE;
        end else begin
            if (i_cmd.latch) begin
                r_rest_pending <= 1'b0;
                r_sound        <= SND_NONE;
            end
            if (i_cmd.tick_upd) begin
                if (r_phase && (r_elapsed < SHOW_CAP)) begin
                    r_elapsed <= r_elapsed + SHOW_W'(1);
                end
            end
            if (i_cmd.start_phase) begin
                r_phase       <= 1'b1;
                r_elapsed     <= '0;
                r_phase_start <= r_now;
                r_sound       <= SND_START;
            end
            if (i_cmd.end_phase) begin
                r_phase        <= 1'b0;
                r_rest_pending <= 1'b1;
                if (long_phase) begin
                    if ((r_newest == r_oldest) && !r_empty) begin
                        r_oldest <= oldest_inc;
                    end
                    r_empty       <= 1'b0;
                    r_newest      <= newest_inc;
                    r_phase_start <= r_now;
                end
            end
            if (i_cmd.clear_log) begin
                r_phase      <= 1'b0;
                r_elapsed    <= '0;
                r_oldest     <= '0;
                r_newest     <= '0;
                r_chime_done <= 1'b0;
                r_empty      <= 1'b1;
            end
            if (i_cmd.expire_step) begin
                r_oldest <= oldest_inc;
                if (oldest_inc == r_newest) begin
                    r_empty <= 1'b1;
                end
            end
            if (i_cmd.decide && r_rest_pending) begin
                if (chime_ok) begin
                    r_chime_done <= 1'b1;
                    r_sound      <= SND_CHIME;
                end else begin
                    r_sound <= SND_REST;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op        <= i_op;
            r_now       <= i_now;
            r_win_start <= win_start;
        end
        if (i_cmd.cap_last) begin
            r_last_time <= rdata;
        end
        if (i_cmd.cap_gap) begin
            r_gap <= quotient;
        end else if (i_cmd.gap_zero) begin
            r_gap <= '0;
        end
        if (i_cmd.load_out) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, r_sound, count_out, shown, r_phase};
        end
    end

    // timestamp log
    eit_ram #(
        .WIDTH (TIME_W),
        .DEPTH (LOG_DEPTH)
    ) u_log (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_newest),
        .i_wdata (r_now),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // average gap divider
    eit_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_last_time - rdata),
        .i_divisor  (count - CNT_W'(1)),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    // status: op, phase, log empty, fewer than two, entry expired, divide done
    assign o_stat = {t_op'(r_op), r_phase, r_empty, (count < CNT_W'(2)),
                     (rdata < r_win_start), div_done};

    assign o_out_data = r_out_data;

endmodule

// ----- hw/rtl/eit_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eit_ctrl: controller of the event interval tracker
// Sequences one item: operation, window expiry walk, average gap divide,
// sound decision and the output register load.
// ----------------------------------------------------------------------------
module eit_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output eit_pkg::t_dp_cmd    o_cmd,
    input  eit_pkg::t_dp_status i_stat
);

    import eit_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OP,
        S_EXP_RD,
        S_EXP_CMP,
        S_GAP_CHK,
        S_GAP_RD2,
        S_GAP_SUB,
        S_GAP_DIV,
        S_SOUND,
        S_OUT
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;

    // next state and commands
    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = S_OP;
                end
            end
            S_OP: begin
                unique case (i_stat.op)
                    OP_TICK: begin
                        cmd.tick_upd = 1'b1;
                        n_state      = S_EXP_RD;
                    end
                    OP_PRESS: begin
                        if (!i_stat.phase) begin
                            cmd.start_phase = 1'b1;
                            n_state         = S_OUT;
                        end else begin
                            cmd.end_phase = 1'b1;
                            n_state       = S_GAP_CHK;
                        end
                    end
                    OP_CLEAR: begin
                        cmd.clear_log = 1'b1;
                        n_state       = S_GAP_CHK;
                    end
                    default: n_state = S_GAP_CHK;
                endcase
            end
            S_EXP_RD: begin
                n_state = i_stat.log_empty ? S_GAP_CHK : S_EXP_CMP;
            end
            S_EXP_CMP: begin
                if (i_stat.expire_old) begin
                    cmd.expire_step = 1'b1;
                    n_state         = S_EXP_RD;
                end else begin
                    n_state = S_GAP_CHK;
                end
            end
            S_GAP_CHK: begin
                if (i_stat.phase) begin
                    n_state = S_SOUND;
                end else if (i_stat.few) begin
                    cmd.gap_zero = 1'b1;
                    n_state      = S_SOUND;
                end else begin
                    cmd.rd_last = 1'b1;
                    n_state     = S_GAP_RD2;
                end
            end
            S_GAP_RD2: begin
                cmd.cap_last = 1'b1;
                n_state      = S_GAP_SUB;
            end
            S_GAP_SUB: begin
                cmd.div_start = 1'b1;
                n_state       = S_GAP_DIV;
            end
            S_GAP_DIV: begin
                if (i_stat.div_done) begin
                    cmd.cap_gap = 1'b1;
                    n_state     = S_SOUND;
                end
            end
            S_SOUND: begin
                cmd.decide = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output slot occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    // one item at a time: no transfer right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in work");

    // result only loaded into a free or draining slot
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

    // divider finishes only while the controller waits for it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_GAP_DIV))
        else $error("divider done outside the divide wait");

    // expiry never steps past an empty log
    a_exp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.expire_step |-> (!i_stat.log_empty && i_stat.expire_old))
        else $error("expiry step on empty log or fresh entry");
`endif

endmodule

// ----- hw/rtl/event_interval_tracker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_interval_tracker_unit: two-phase event timer with a windowed log
//
//   channel   direction  signals                        transfer when
//   s_axis    in         tvalid tready tdata tuser      tvalid && tready
//   m_axis    out        tvalid tready tdata            tvalid && tready
//   cfg       in         valid ready index data         valid && ready
//
// One item at a time; the expiry walk reads the log once per dropped entry
// (one RAM read port) and the average gap takes two log reads and a
// 32-step serial divide.
// Reset is synchronous, active low; the log RAM is not cleared, its fill is
// tracked by the oldest/newest indices. A result waits in the output register
// while the next item is taken; only a second pending result stalls the block.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module event_interval_tracker_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tdata: [31:0] now_seconds
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [eit_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: [1:0] operation
    input  logic [eit_pkg::OP_W-1:0]       s_axis_tuser,
    // tdata: [0] phase, [12:1] display_seconds, [17:13] event_count,
    //        [19:18] sound, [23:20] zero
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [eit_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [eit_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [eit_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import eit_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status stat;

    eit_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    eit_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (s_axis_tuser),
        .i_now       (s_axis_tdata[TIME_W-1:0]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (m_axis_tdata)
    );

    assign o_cfg_ready = 1'b1;

endmodule
